/* sv/flec_pkg.sv */
`default_nettype none

package flec_pkg;

    localparam logic [63:0] GEN_LIMIT = 64'hFFFF_FFFF_FFFF_FFFE;

    typedef enum logic [3:0] {
        EV_CREATE       = 4'd0,
        EV_LOAD_DONE    = 4'd1,
        EV_WARM_DONE    = 4'd2,
        EV_BEGIN_DRAIN  = 4'd3,
        EV_CANCEL_DRAIN = 4'd4,
        EV_DRAIN_DONE   = 4'd5,
        EV_TERM_DONE    = 4'd6,
        EV_OP_FAILED    = 4'd7,
        EV_CLEANUP      = 4'd8
    } event_t;

    typedef enum logic [2:0] {
        PH_ABSENT    = 3'd0,
        PH_LOADING   = 3'd1,
        PH_WARMING   = 3'd2,
        PH_READY     = 3'd3,
        PH_DRAINING  = 3'd4,
        PH_UNLOADING = 3'd5,
        PH_FAILED    = 3'd6
    } phase_t;

    typedef enum logic [2:0] {
        ST_APPLIED    = 3'd0,
        ST_REPLAYED   = 3'd1,
        ST_BAD_INPUT  = 3'd2,
        ST_FENCED     = 3'd3,
        ST_CONFLICT   = 3'd4,
        ST_BAD_TRANS  = 3'd5,
        ST_CLOCK_BACK = 3'd6,
        ST_EXHAUSTED  = 3'd7
    } status_t;

    // One command as it travels from the input register to the checker.
    typedef struct packed {
        logic [3:0]  event_req;
        logic [63:0] engine_id;
        logic [63:0] incarnation_id;
        logic [63:0] operation_ref;
        logic [63:0] wanted_generation;
        logic [63:0] observed_ms;
    } item_t;

    // Record fields whose width does not depend on the id width.
    typedef struct packed {
        phase_t      phase;
        logic [63:0] state_gen;
        logic [63:0] held_wanted_gen;
        logic [8:0]  applied_events;
        logic        drain_locked;
        logic [63:0] last_change_ms;
    } core_t;

    typedef struct packed {
        logic   ok;
        phase_t next;
    } move_t;

    function automatic move_t legal_move(phase_t ph, logic [3:0] ev, logic committed);
        move_t m;
        m.ok   = 1'b0;
        m.next = ph;
        unique case (ph)
            PH_ABSENT:
            begin
                if (ev == EV_CREATE)
                begin
                    m.ok = 1'b1; m.next = PH_LOADING;
                end
            end
            PH_LOADING:
            begin
                if (ev == EV_LOAD_DONE)
                begin
                    m.ok = 1'b1; m.next = PH_WARMING;
                end
                else if (ev == EV_OP_FAILED)
                begin
                    m.ok = 1'b1; m.next = PH_FAILED;
                end
            end
            PH_WARMING:
            begin
                if (ev == EV_WARM_DONE)
                begin
                    m.ok = 1'b1; m.next = PH_READY;
                end
                else if (ev == EV_OP_FAILED)
                begin
                    m.ok = 1'b1; m.next = PH_FAILED;
                end
            end
            PH_READY:
            begin
                if (ev == EV_BEGIN_DRAIN)
                begin
                    m.ok = 1'b1; m.next = PH_DRAINING;
                end
            end
            PH_DRAINING:
            begin
                if (ev == EV_CANCEL_DRAIN && !committed)
                begin
                    m.ok = 1'b1; m.next = PH_READY;
                end
                else if (ev == EV_DRAIN_DONE)
                begin
                    m.ok = 1'b1; m.next = PH_UNLOADING;
                end
                else if (ev == EV_OP_FAILED)
                begin
                    m.ok = 1'b1; m.next = PH_FAILED;
                end
            end
            PH_UNLOADING:
            begin
                if (ev == EV_TERM_DONE)
                begin
                    m.ok = 1'b1; m.next = PH_ABSENT;
                end
                else if (ev == EV_OP_FAILED)
                begin
                    m.ok = 1'b1; m.next = PH_FAILED;
                end
            end
            PH_FAILED:
            begin
                if (ev == EV_CLEANUP)
                begin
                    m.ok = 1'b1; m.next = PH_ABSENT;
                end
            end
            default:
            begin
                m.ok = 1'b0;
            end
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

/* sv/flec_if.sv */
`default_nettype none

interface flec_cmd_if;
    logic        valid;
    logic        ready;
    logic [3:0]  event_req;
    logic [63:0] engine_id;
    logic [63:0] incarnation_id;
    logic [63:0] operation_ref;
    logic [63:0] wanted_generation;
    logic [63:0] observed_ms;

    modport source (
        output valid, event_req, engine_id, incarnation_id, operation_ref,
               wanted_generation, observed_ms,
        input  ready
    );
    modport sink (
        input  valid, event_req, engine_id, incarnation_id, operation_ref,
               wanted_generation, observed_ms,
        output ready
    );
endinterface

interface flec_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [2:0]  phase_out;
    logic [63:0] generation_out;
    logic        drain_flag_out;
    logic [8:0]  applied_out;

    modport source (
        output valid, status, phase_out, generation_out, drain_flag_out, applied_out,
        input  ready
    );
    modport sink (
        input  valid, status, phase_out, generation_out, drain_flag_out, applied_out,
        output ready
    );
endinterface

`default_nettype wire

/* sv/flec_check.sv */
`default_nettype none

module flec_check #(
    parameter int ID_WIDTH = 64
) (
    input  flec_pkg::item_t        item,
    input  flec_pkg::core_t        core,
    input  logic [ID_WIDTH-1:0]    held_engine,
    input  logic [ID_WIDTH-1:0]    held_incarnation,
    input  logic [ID_WIDTH-1:0]    held_operation,
    output flec_pkg::status_t      status,
    output flec_pkg::core_t        core_next,
    output logic [ID_WIDTH-1:0]    engine_next,
    output logic [ID_WIDTH-1:0]    incarnation_next,
    output logic [ID_WIDTH-1:0]    operation_next
);
    import flec_pkg::*;

    logic [3:0]          ev;
    logic [ID_WIDTH-1:0] eng;
    logic [ID_WIDTH-1:0] inc;
    logic [ID_WIDTH-1:0] op;
    logic [63:0]         wg;
    logic [63:0]         obs;
    logic                bad;
    logic                older;
    logic                match;
    logic                same;
    logic                opens;
    logic                seen;
    logic                clk_back;
    logic [8:0]          ev_bit;
    logic [8:0]          applied_base;
    move_t               move;

    // Drop id bits above the configured id width before any check.
    assign ev  = item.event_req;
    assign eng = item.engine_id[ID_WIDTH-1:0];
    assign inc = item.incarnation_id[ID_WIDTH-1:0];
    assign op  = item.operation_ref[ID_WIDTH-1:0];
    assign wg  = item.wanted_generation;
    assign obs = item.observed_ms;

    assign bad = (ev > EV_CLEANUP) || (eng == '0) || (inc == '0) || (op == '0)
                 || (wg == 64'd0) || (obs == 64'd0);
    assign older    = wg < core.held_wanted_gen;
    assign match    = (held_engine == eng) && (held_incarnation == inc);
    assign same     = (op == held_operation) && (wg == core.held_wanted_gen);
    assign opens    = (ev == EV_CREATE) || (ev == EV_BEGIN_DRAIN)
                      || (ev == EV_CANCEL_DRAIN) || (ev == EV_CLEANUP);
    assign ev_bit   = 9'd1 << ev;
    assign seen     = same && ((core.applied_events & ev_bit) != 9'd0);
    assign clk_back = (core.last_change_ms != 64'd0) && (obs < core.last_change_ms);
    assign move     = legal_move(core.phase, ev, core.drain_locked);

    always_comb
    begin
        priority if (bad)
            status = ST_BAD_INPUT;
        else if (older)
            status = ST_FENCED;
        else if (same && !match)
            status = ST_FENCED;
        else if (seen)
            status = ST_REPLAYED;
        else if (clk_back)
            status = ST_CLOCK_BACK;
        else if (!same && ((wg <= core.held_wanted_gen) || !opens))
            status = ST_CONFLICT;
        else if (!same && (ev != EV_CREATE) && !match)
            status = ST_FENCED;
        else if (!same && (ev == EV_CREATE) && (held_engine != '0) && match)
            status = ST_FENCED;
        else if (!move.ok)
            status = ST_BAD_TRANS;
        else if (core.state_gen == GEN_LIMIT)
            status = ST_EXHAUSTED;
        else
            status = ST_APPLIED;
    end

    // Next record: unchanged unless every check passed.
    always_comb
    begin
        core_next        = core;
        engine_next      = held_engine;
        incarnation_next = held_incarnation;
        operation_next   = held_operation;
        applied_base     = same ? core.applied_events : 9'd0;
        if (status == ST_APPLIED)
        begin
            if (!same)
            begin
                operation_next       = op;
                core_next.held_wanted_gen = wg;
            end
            if (ev == EV_CREATE)
            begin
                engine_next            = eng;
                incarnation_next       = inc;
                core_next.drain_locked = 1'b0;
            end
            else if (ev == EV_DRAIN_DONE)
                core_next.drain_locked = 1'b1;
            else if (ev == EV_CANCEL_DRAIN)
                core_next.drain_locked = 1'b0;
            core_next.phase          = move.next;
            core_next.state_gen      = core.state_gen + 64'd1;
            core_next.applied_events = applied_base | ev_bit;
            core_next.last_change_ms = obs;
        end
    end

endmodule

`default_nettype wire

/* sv/fenced_lifecycle_event_checker.sv */
// Fenced lifecycle event checker.
//
// Holds one lifecycle record and checks each command against it. Commands
// arrive on cmd (valid/ready); one response per command leaves on rsp with
// the status and the record as it stands after the command.
//
// Pipeline: a command transfer loads the input register; once the response
// register is free or rsp is ready, the checker's verdict and the updated
// record are written to the response register and to the record at once,
// and rsp.valid rises. One command per cycle is sustained while rsp does not
// stall: the record update is a single pass of compares and small adds, so
// the following command sees the new record with no bubble.
//
// When rsp stalls, the response register holds and the input register still
// takes one more command; cmd.ready drops only when both are full.
//
// Reset (rst_n low, asynchronous) empties both stages and returns the record
// to phase absent with all ids, generations, mask, flag and time at zero.
`default_nettype none

module fenced_lifecycle_event_checker #(
    parameter int ID_WIDTH = 64
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    flec_cmd_if.sink   cmd,
    flec_rsp_if.source rsp
);
    import flec_pkg::*;

    // Input stage
    logic                in_valid_reg;
    item_t               in_item_reg;
    item_t               cmd_item;

    // Lifecycle record
    core_t               core_reg;
    logic [ID_WIDTH-1:0] engine_reg;
    logic [ID_WIDTH-1:0] incarnation_reg;
    logic [ID_WIDTH-1:0] operation_reg;

    // Checker results
    status_t             chk_status;
    core_t               core_next;
    logic [ID_WIDTH-1:0] engine_next;
    logic [ID_WIDTH-1:0] incarnation_next;
    logic [ID_WIDTH-1:0] operation_next;

    // Response stage
    logic                out_valid_reg;
    status_t             out_status_reg;
    core_t               out_core_reg;

    logic                advance;
    logic                cmd_xfer;

    // Advance the input stage when the response register is free or draining.
    assign advance  = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign cmd.ready = !in_valid_reg || advance;
    assign cmd_xfer = cmd.valid && cmd.ready;

    assign cmd_item = '{
        event_req:         cmd.event_req,
        engine_id:         cmd.engine_id,
        incarnation_id:    cmd.incarnation_id,
        operation_ref:     cmd.operation_ref,
        wanted_generation: cmd.wanted_generation,
        observed_ms:       cmd.observed_ms
    };

    flec_check #(
        .ID_WIDTH (ID_WIDTH)
    ) u_check (
        .item             (in_item_reg),
        .core             (core_reg),
        .held_engine      (engine_reg),
        .held_incarnation (incarnation_reg),
        .held_operation   (operation_reg),
        .status           (chk_status),
        .core_next        (core_next),
        .engine_next      (engine_next),
        .incarnation_next (incarnation_next),
        .operation_next   (operation_next)
    );

    // Input register: valid bit under reset, payload without.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (cmd.ready)
            in_valid_reg <= cmd.valid;
    end

    always_ff @(posedge clk)
    begin
        if (cmd_xfer)
            in_item_reg <= cmd_item;
    end

    // Record: commit the checker's next record as the command leaves the
    // input stage. A rejected command writes back the unchanged record.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            core_reg        <= '{phase: PH_ABSENT, default: '0};
            engine_reg      <= '0;
            incarnation_reg <= '0;
            operation_reg   <= '0;
        end
        else if (advance)
        begin
            core_reg        <= core_next;
            engine_reg      <= engine_next;
            incarnation_reg <= incarnation_next;
            operation_reg   <= operation_next;
        end
    end

    // Response register: hold while rsp stalls.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (!out_valid_reg || rsp.ready)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_status_reg <= chk_status;
            out_core_reg   <= core_next;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.phase_out      = out_core_reg.phase;
    assign rsp.generation_out = out_core_reg.state_gen;
    assign rsp.drain_flag_out = out_core_reg.drain_locked;
    assign rsp.applied_out    = out_core_reg.applied_events;

    // An applied command bumps the generation by exactly one.
    a_gen_step: assert property (
        @(posedge clk) disable iff (!rst_n)
        (advance && chk_status == ST_APPLIED)
            |=> core_reg.state_gen == $past(core_reg.state_gen) + 64'd1
    ) else $error("generation did not advance on an applied command");

    // A rejected command leaves the whole record untouched.
    a_reject_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        (advance && chk_status != ST_APPLIED)
            |=> ($stable(core_reg) && $stable(engine_reg)
                 && $stable(incarnation_reg) && $stable(operation_reg))
    ) else $error("record changed on a rejected command");

    // An operation is held exactly when some event of it has been applied.
    a_op_mask: assert property (
        @(posedge clk) disable iff (!rst_n)
        (operation_reg != '0) == (core_reg.applied_events != 9'd0)
    ) else $error("held operation and applied mask disagree");

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps

module testbench;
    import flec_pkg::*;

    // Event codes above cleanup are not defined; the block must flag them as bad input.
    localparam logic [3:0]  EV_BAD_LOW  = 4'd9;
    localparam logic [3:0]  EV_BAD_HIGH = 4'd15;
    localparam logic [63:0] ALL_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] ENG_A       = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] INC_A       = 64'h8000_0000_0000_0000;
    localparam int          RANDOM_CMDS = 1100;
    localparam int          QUIET_TAIL  = 150;
    localparam int          LONG_HOLD   = 64;
    localparam int          CYCLE_LIMIT = 200000;

    // Lifecycle record as the scoreboard tracks it.
    typedef struct packed {
        phase_t      phase;
        logic [63:0] gen;
        logic [63:0] eng;
        logic [63:0] inc;
        logic [63:0] op;
        logic [63:0] wg;
        logic [8:0]  applied;
        logic        drain;
        logic [63:0] last_ms;
    } record_t;

    // One response as it should leave the block.
    typedef struct packed {
        status_t     st;
        phase_t      ph;
        logic [63:0] gen;
        logic        drain;
        logic [8:0]  app;
    } verdict_t;

    typedef struct packed {
        item_t    c;
        logic     typed;
        verdict_t want;
    } cmd_row_t;

    logic clk = 1'b0;
    logic rst_n;

    flec_cmd_if cmd_ch ();
    flec_rsp_if rsp_ch ();

    fenced_lifecycle_event_checker dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    record_t  rec;
    verdict_t expected_verdicts[$];
    cmd_row_t directed_rows[$];
    int       mismatches     = 0;
    int       verdicts_seen  = 0;
    int       cycle_count    = 0;
    bit       gaps_on        = 1'b1;
    bit       long_hold_done = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Abort a hung run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("ERROR: response %0d, %s: got %0h, expected %0h",
                 verdicts_seen, what, got, want);
        mismatches++;
    endtask

    function automatic logic [63:0] nz64();
        logic [63:0] v;
        v = {$urandom, $urandom};
        if (v == 64'd0)
            v = 64'd1;
        return v;
    endfunction

    // Evaluate one command against record r. The record after the command
    // comes back in n; it equals r unless every check passes.
    function automatic status_t lifecycle_step(input record_t r, input item_t c,
                                               output record_t n);
        logic [3:0] ev;
        logic [8:0] ev_bit;
        logic       same;
        logic       match;
        logic       opens;
        logic       ok;
        phase_t     nx;
        n  = r;
        ev = c.event_req;
        if (ev > EV_CLEANUP || c.engine_id == 64'd0 || c.incarnation_id == 64'd0 ||
            c.operation_ref == 64'd0 || c.wanted_generation == 64'd0 ||
            c.observed_ms == 64'd0)
            return ST_BAD_INPUT;
        // Older generation than the one held: stale writer.
        if (c.wanted_generation < r.wg)
            return ST_FENCED;
        ev_bit = 9'b1 << ev;
        match  = (r.eng == c.engine_id) && (r.inc == c.incarnation_id);
        same   = (r.op == c.operation_ref) && (r.wg == c.wanted_generation);
        opens  = (ev == EV_CREATE) || (ev == EV_BEGIN_DRAIN) ||
                 (ev == EV_CANCEL_DRAIN) || (ev == EV_CLEANUP);
        if (same && !match)
            return ST_FENCED;
        if (same && (r.applied & ev_bit) != 9'd0)
            return ST_REPLAYED;
        // Zero time means the record never changed; skip the clock check then.
        if (r.last_ms != 64'd0 && c.observed_ms < r.last_ms)
            return ST_CLOCK_BACK;
        if (!same)
        begin
            if (c.wanted_generation <= r.wg || !opens)
                return ST_CONFLICT;
            if (ev != EV_CREATE && !match)
                return ST_FENCED;
            if (ev == EV_CREATE && r.eng != 64'd0 && match)
                return ST_FENCED;
        end
        // Transition table; op failure is legal from every busy phase.
        ok = 1'b1;
        nx = PH_ABSENT;
        if (ev == EV_OP_FAILED && (r.phase == PH_LOADING || r.phase == PH_WARMING ||
                                   r.phase == PH_DRAINING || r.phase == PH_UNLOADING))
            nx = PH_FAILED;
        else if (r.phase == PH_ABSENT && ev == EV_CREATE)
            nx = PH_LOADING;
        else if (r.phase == PH_LOADING && ev == EV_LOAD_DONE)
            nx = PH_WARMING;
        else if (r.phase == PH_WARMING && ev == EV_WARM_DONE)
            nx = PH_READY;
        else if (r.phase == PH_READY && ev == EV_BEGIN_DRAIN)
            nx = PH_DRAINING;
        else if (r.phase == PH_DRAINING && ev == EV_CANCEL_DRAIN && !r.drain)
            nx = PH_READY;
        else if (r.phase == PH_DRAINING && ev == EV_DRAIN_DONE)
            nx = PH_UNLOADING;
        else if (r.phase == PH_UNLOADING && ev == EV_TERM_DONE)
            nx = PH_ABSENT;
        else if (r.phase == PH_FAILED && ev == EV_CLEANUP)
            nx = PH_ABSENT;
        else
            ok = 1'b0;
        if (!ok)
            return ST_BAD_TRANS;
        if (r.gen == GEN_LIMIT)
            return ST_EXHAUSTED;
        // Commit.
        if (!same)
        begin
            n.op      = c.operation_ref;
            n.wg      = c.wanted_generation;
            n.applied = 9'd0;
        end
        if (ev == EV_CREATE)
        begin
            n.eng   = c.engine_id;
            n.inc   = c.incarnation_id;
            n.drain = 1'b0;
        end
        else if (ev == EV_DRAIN_DONE)
            n.drain = 1'b1;
        else if (ev == EV_CANCEL_DRAIN)
            n.drain = 1'b0;
        n.phase   = nx;
        n.gen     = r.gen + 64'd1;
        n.applied = n.applied | ev_bit;
        n.last_ms = c.observed_ms;
        return ST_APPLIED;
    endfunction

    // Build the next command of a well-behaved lifecycle from the record.
    function automatic item_t lifecycle_cmd(input record_t r);
        item_t c;
        logic  fresh;
        int    roll;
        c.engine_id         = r.eng;
        c.incarnation_id    = r.inc;
        c.operation_ref     = r.op;
        c.wanted_generation = r.wg;
        c.observed_ms       = r.last_ms + $urandom_range(0, 20);
        fresh = 1'b0;
        roll  = $urandom_range(0, 5);
        case (r.phase)
            PH_ABSENT:
            begin
                // A new incarnation is needed, else create is fenced.
                c.event_req      = EV_CREATE;
                fresh            = 1'b1;
                c.incarnation_id = nz64();
                if (r.eng == 64'd0 || roll < 2)
                    c.engine_id = nz64();
            end
            PH_LOADING:
                c.event_req = (roll == 0) ? EV_OP_FAILED : EV_LOAD_DONE;
            PH_WARMING:
                c.event_req = (roll == 0) ? EV_OP_FAILED : EV_WARM_DONE;
            PH_READY:
            begin
                c.event_req = EV_BEGIN_DRAIN;
                fresh       = (roll != 0);
            end
            PH_DRAINING:
            begin
                if (roll < 2)
                begin
                    c.event_req = EV_CANCEL_DRAIN;
                    fresh       = (roll == 0);
                end
                else
                    c.event_req = (roll == 5) ? EV_OP_FAILED : EV_DRAIN_DONE;
            end
            PH_UNLOADING:
                c.event_req = (roll == 0) ? EV_OP_FAILED : EV_TERM_DONE;
            default:
            begin
                c.event_req = EV_CLEANUP;
                fresh       = (roll > 1);
            end
        endcase
        if (fresh)
        begin
            c.operation_ref     = nz64();
            c.wanted_generation = r.wg + $urandom_range(1, 1000);
        end
        return c;
    endfunction

    // Pick a field value near the held one, at an extreme, or at random.
    function automatic logic [63:0] any_value(input logic [63:0] base);
        case ($urandom_range(0, 9))
            0:       return 64'd0;
            1:       return ALL_ONES;
            2:       return {$urandom, $urandom};
            3:       return base - 64'd1;
            4:       return base + $urandom_range(1, 30);
            default: return base;
        endcase
    endfunction

    function automatic item_t noise_cmd(input record_t r);
        item_t c;
        c.event_req         = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                          : 4'($urandom_range(0, 8));
        c.engine_id         = any_value(r.eng);
        c.incarnation_id    = any_value(r.inc);
        c.operation_ref     = any_value(r.op);
        c.wanted_generation = any_value(r.wg);
        c.observed_ms       = any_value(r.last_ms);
        return c;
    endfunction

    task automatic add_row(input logic [3:0] ev, input logic [63:0] eng,
                           input logic [63:0] inc, input logic [63:0] op,
                           input logic [63:0] wg, input logic [63:0] ms,
                           input logic typed, input status_t st, input phase_t ph,
                           input logic [63:0] gen, input logic drain,
                           input logic [8:0] app);
        cmd_row_t row;
        row.c     = '{ev, eng, inc, op, wg, ms};
        row.typed = typed;
        row.want  = '{st, ph, gen, drain, app};
        directed_rows.push_back(row);
    endtask

    // Predict the command, queue its verdict, then hold it on the channel
    // until the block takes the transfer. Enter and leave at a falling edge.
    task automatic issue(input item_t c, input logic typed, input verdict_t want);
        record_t  nxt;
        verdict_t e;
        status_t  st;
        st  = lifecycle_step(rec, c, nxt);
        rec = nxt;
        if (typed)
            e = want;
        else
            e = '{st, nxt.phase, nxt.gen, nxt.drain, nxt.applied};
        expected_verdicts.push_back(e);
        if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        cmd_ch.valid             <= 1'b1;
        cmd_ch.event_req         <= c.event_req;
        cmd_ch.engine_id         <= c.engine_id;
        cmd_ch.incarnation_id    <= c.incarnation_id;
        cmd_ch.operation_ref     <= c.operation_ref;
        cmd_ch.wanted_generation <= c.wanted_generation;
        cmd_ch.observed_ms       <= c.observed_ms;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        @(negedge clk);
    endtask

    // Response side: random stall bursts, one long hold-off to back the
    // block up into its command channel, and no stalls in the quiet tail.
    initial
    begin
        int hold_left;
        hold_left    = 0;
        rsp_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (!long_hold_done && verdicts_seen >= 400)
            begin
                long_hold_done = 1'b1;
                rsp_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
            end
            else if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (gaps_on && $urandom_range(0, 5) == 0)
            begin
                hold_left = $urandom_range(0, 3);
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // Compare every response transfer with the oldest queued verdict.
    always @(posedge clk)
    begin
        verdict_t e;
        if (rst_n === 1'b1 && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_verdicts.size() == 0)
                report_mismatch("unexpected response", {61'd0, rsp_ch.status}, 64'd0);
            else
            begin
                e = expected_verdicts.pop_front();
                if (rsp_ch.status !== e.st)
                    report_mismatch("status", rsp_ch.status, e.st);
                if (rsp_ch.phase_out !== e.ph)
                    report_mismatch("phase_out", rsp_ch.phase_out, e.ph);
                if (rsp_ch.generation_out !== e.gen)
                    report_mismatch("generation_out", rsp_ch.generation_out, e.gen);
                if (rsp_ch.drain_flag_out !== e.drain)
                    report_mismatch("drain_flag_out", rsp_ch.drain_flag_out, e.drain);
                if (rsp_ch.applied_out !== e.app)
                    report_mismatch("applied_out", rsp_ch.applied_out, e.app);
            end
            verdicts_seen++;
        end
    end

    initial
    begin
        item_t    c;
        item_t    prev_c;
        record_t  peek;
        status_t  st;
        verdict_t none;
        int       roll;
        rst_n                    = 1'b0;
        cmd_ch.valid             = 1'b0;
        cmd_ch.event_req         = 4'd0;
        cmd_ch.engine_id         = 64'd0;
        cmd_ch.incarnation_id    = 64'd0;
        cmd_ch.operation_ref     = 64'd0;
        cmd_ch.wanted_generation = 64'd0;
        cmd_ch.observed_ms       = 64'd0;
        rec                      = '0;
        none                     = '0;

        // Walk the record through every phase and every check but exhaustion. Rows with
        // typed=1 carry their verdict; the rest rely on the scoreboard.
        // Bad input: undefined codes and each zero field.
        add_row(EV_BAD_LOW, 1, 1, 1, 1, 1, 1, ST_BAD_INPUT, PH_ABSENT, 0, 0, 9'h000);
        add_row(EV_BAD_HIGH, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES,
                1, ST_BAD_INPUT, PH_ABSENT, 0, 0, 9'h000);
        add_row(EV_CREATE, 0, 1, 1, 1, 1, 1, ST_BAD_INPUT, PH_ABSENT, 0, 0, 9'h000);
        add_row(EV_CREATE, 1, 0, 0, 1, 1, 1, ST_BAD_INPUT, PH_ABSENT, 0, 0, 9'h000);
        add_row(EV_CREATE, 1, 1, 1, 0, 0, 1, ST_BAD_INPUT, PH_ABSENT, 0, 0, 9'h000);
        // Top generation on an event that cannot open an operation.
        add_row(EV_LOAD_DONE, 1, 1, 1, ALL_ONES, 1, 1, ST_CONFLICT, PH_ABSENT, 0, 0, 9'h000);
        add_row(EV_CREATE, ENG_A, INC_A, ALL_ONES, 10, 100,
                1, ST_APPLIED, PH_LOADING, 1, 0, 9'h001);
        add_row(EV_LOAD_DONE, ENG_A, INC_A, ALL_ONES, 10, 100,
                1, ST_APPLIED, PH_WARMING, 2, 0, 9'h003);
        add_row(EV_LOAD_DONE, ENG_A, INC_A, ALL_ONES, 10, 100,
                1, ST_REPLAYED, PH_WARMING, 2, 0, 9'h003);
        add_row(EV_WARM_DONE, ENG_A, INC_A, ALL_ONES, 10, 99,
                1, ST_CLOCK_BACK, PH_WARMING, 2, 0, 9'h003);
        add_row(EV_WARM_DONE, ENG_A, INC_A, ALL_ONES, 9, 150,
                1, ST_FENCED, PH_WARMING, 2, 0, 9'h003);
        // Same operation from another incarnation.
        add_row(EV_WARM_DONE, ENG_A, 1, ALL_ONES, 10, 150,
                1, ST_FENCED, PH_WARMING, 2, 0, 9'h003);
        add_row(EV_CANCEL_DRAIN, ENG_A, INC_A, ALL_ONES, 10, 150,
                1, ST_BAD_TRANS, PH_WARMING, 2, 0, 9'h003);
        add_row(EV_WARM_DONE, ENG_A, INC_A, ALL_ONES, 10, 200,
                1, ST_APPLIED, PH_READY, 3, 0, 9'h007);
        add_row(EV_BEGIN_DRAIN, ENG_A, INC_A, 2, 11, 200,
                0, ST_APPLIED, PH_ABSENT, 0, 0, 9'h000);
        // Re-create by the engine already holding the record.
        add_row(EV_CREATE, ENG_A, INC_A, 3, 12, 200,
                1, ST_FENCED, PH_DRAINING, 4, 0, 9'h008);
        add_row(EV_BEGIN_DRAIN, 5, INC_A, 3, 12, 200,
                1, ST_FENCED, PH_DRAINING, 4, 0, 9'h008);
        add_row(EV_CANCEL_DRAIN, ENG_A, INC_A, 2, 11, 250,
                0, ST_APPLIED, PH_ABSENT, 0, 0, 9'h000);
        add_row(EV_BEGIN_DRAIN, ENG_A, INC_A, 2, 11, 250,
                1, ST_REPLAYED, PH_READY, 5, 0, 9'h018);
        add_row(EV_BEGIN_DRAIN, ENG_A, INC_A, 4, 20, 300,
                0, ST_APPLIED, PH_ABSENT, 0, 0, 9'h000);
        add_row(EV_DRAIN_DONE, ENG_A, INC_A, 4, 20, 300,
                0, ST_APPLIED, PH_ABSENT, 0, 0, 9'h000);
        add_row(EV_CANCEL_DRAIN, ENG_A, INC_A, 4, 20, 300,
                1, ST_BAD_TRANS, PH_UNLOADING, 7, 1, 9'h028);
        add_row(EV_OP_FAILED, ENG_A, INC_A, 4, 20, 301,
                0, ST_APPLIED, PH_ABSENT, 0, 0, 9'h000);
        add_row(EV_CLEANUP, ENG_A, INC_A, 5, 21, 302,
                0, ST_APPLIED, PH_ABSENT, 0, 0, 9'h000);
        add_row(EV_CREATE, 1, 1, 6, 22, 400, 0, ST_APPLIED, PH_ABSENT, 0, 0, 9'h000);
        add_row(EV_OP_FAILED, 1, 1, 6, 22, 500, 0, ST_APPLIED, PH_ABSENT, 0, 0, 9'h000);
        // Latest possible time on a rejected command keeps the clock usable.
        add_row(EV_TERM_DONE, 1, 1, 6, 22, ALL_ONES,
                1, ST_BAD_TRANS, PH_FAILED, 11, 0, 9'h081);

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            issue(directed_rows[i].c, directed_rows[i].typed, directed_rows[i].want);

        prev_c = directed_rows[directed_rows.size() - 1].c;
        for (int i = 0; i < RANDOM_CMDS; i++)
        begin
            // Run the tail with no stalls on either side.
            if (i == RANDOM_CMDS - QUIET_TAIL)
                gaps_on = 1'b0;
            roll = $urandom_range(0, 99);
            if (roll < 65)
                c = lifecycle_cmd(rec);
            else if (roll < 75)
                c = prev_c;
            else if (roll < 80)
            begin
                c = lifecycle_cmd(rec);
                if (rec.last_ms > 64'd1)
                    c.observed_ms = rec.last_ms - 64'd1;
            end
            else
            begin
                // Drop noise that would push generation or time so far that
                // later lifecycles could no longer move forward.
                do
                begin
                    c  = noise_cmd(rec);
                    st = lifecycle_step(rec, c, peek);
                end
                while (st == ST_APPLIED && (c.wanted_generation[63:40] != 24'd0 ||
                                            c.observed_ms[63:40] != 24'd0));
            end
            prev_c = c;
            issue(c, 1'b0, none);
        end
        cmd_ch.valid <= 1'b0;

        while (expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
